// ===== design/tbpp_pkg.sv =====
`default_nettype none
package tbpp_pkg;

	// Pattern dimension limits and register widths.
	localparam int unsigned MAX_WIDTH  = 64;
	localparam int unsigned MAX_HEIGHT = 64;
	localparam int unsigned DIM_W      = 7;
	localparam int unsigned WORD_W     = 16;
	localparam int unsigned POS_W      = 4;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned CFG_IDX_W  = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HEIGHT = 2'd1;

	// Reset value of both dimensions.
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd8;

	// Characters with a special meaning.
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;

	// Bit position of the last bit of a packed word.
	localparam logic [POS_W-1:0] LAST_BIT = 4'd15;

	// Result kinds.
	localparam logic KIND_WORD   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// One result item.
	typedef struct packed {
		logic              result_kind;
		logic [WORD_W-1:0] bitmap_word;
		logic              size_ok;
		logic              is_solid;
		logic              last_of_run;
	} result_t;

endpackage
`default_nettype wire

// ===== design/tbpp_in_if.sv =====
`default_nettype none
interface tbpp_in_if;
	import tbpp_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);

endinterface
`default_nettype wire

// ===== design/tbpp_out_if.sv =====
`default_nettype none
interface tbpp_out_if;
	import tbpp_pkg::*;

	logic              valid;
	logic              ready;
	logic              result_kind;
	logic [WORD_W-1:0] bitmap_word;
	logic              size_ok;
	logic              is_solid;
	logic              last_of_run;

	modport source (
		output valid, output result_kind, output bitmap_word, output size_ok,
		output is_solid, output last_of_run, input ready
	);
	modport sink (
		input valid, input result_kind, input bitmap_word, input size_ok,
		input is_solid, input last_of_run, output ready
	);

endinterface
`default_nettype wire

// ===== design/tbpp_cfg_if.sv =====
`default_nettype none
interface tbpp_cfg_if;
	import tbpp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);

endinterface
`default_nettype wire

// ===== design/text_bitmap_parse_pack_core.sv =====
`default_nettype none
// Text bitmap parser and packer. Each input transaction carries one pattern
// character or the end marker; whitespace is skipped, '0' gives a zero bit and
// any other character a one bit, packed least significant first into 16-bit
// words that leave when full or at the end of a row of pattern_width columns.
// The end marker flushes a partial word and then yields a status transaction
// with size_ok, is_solid and last_of_run set as described, after which the
// counters clear. One character is taken per clock: the parse and pack logic
// is combinational and writes its results into a four-entry result queue,
// and the input is ready while the queue has room for two results, so
// the rate is one item per cycle as long as the output keeps draining.
// Configuration writes are always ready and take effect at once; dimensions
// of 0 are used as 1 and values above 64 as 64.
module text_bitmap_parse_pack_core (
	input  wire logic clk,
	input  wire logic arst_n,
	tbpp_in_if.sink   in_ch,
	tbpp_out_if.source out_ch,
	tbpp_cfg_if.sink  cfg
);
	import tbpp_pkg::*;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	// Configuration registers.
	logic [DIM_W-1:0] pattern_width_q;
	logic [DIM_W-1:0] pattern_height_q;

	// Parse state.
	logic [DIM_W-1:0]  column_count_q;
	logic [DIM_W-1:0]  row_count_q;
	logic [POS_W-1:0]  bit_position_q;
	logic [WORD_W-1:0] word_accumulator_q;
	logic              all_ones_seen_q;
	logic              overflow_seen_q;

	// Result queue.
	result_t           queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic [DIM_W-1:0]  w_eff;
	logic [DIM_W-1:0]  h_eff;
	logic              accept;
	logic              pop;
	logic [1:0]        push_n;
	result_t           res_a;
	result_t           res_b;

	logic [DIM_W-1:0]  column_count_d;
	logic [DIM_W-1:0]  row_count_d;
	logic [POS_W-1:0]  bit_position_d;
	logic [WORD_W-1:0] word_accumulator_d;
	logic              all_ones_seen_d;
	logic              overflow_seen_d;

	logic              is_space;
	logic              pat_bit;
	logic [WORD_W-1:0] acc_ins;
	logic [DIM_W-1:0]  col_inc;
	logic              row_end;
	logic              word_full;
	logic              ok;

	// Clamp the configured dimensions to their legal range.
	always_comb begin
		if (pattern_width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (pattern_width_q > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = pattern_width_q;
		end
		if (pattern_height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (pattern_height_q > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = pattern_height_q;
		end
	end

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign accept      = in_ch.valid & in_ch.ready;
	assign pop         = out_ch.valid & out_ch.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_width_q  <= DIM_RESET;
			pattern_height_q <= DIM_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PATTERN_WIDTH:  pattern_width_q  <= cfg.data;
				REG_PATTERN_HEIGHT: pattern_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Parse and pack one character, or finish the pattern at the end marker.
	always_comb begin
		column_count_d     = column_count_q;
		row_count_d        = row_count_q;
		bit_position_d     = bit_position_q;
		word_accumulator_d = word_accumulator_q;
		all_ones_seen_d    = all_ones_seen_q;
		overflow_seen_d    = overflow_seen_q;
		push_n             = 2'd0;
		res_a              = '0;
		res_b              = '0;

		is_space  = (in_ch.char_code == CH_SPACE) || (in_ch.char_code == CH_TAB) ||
			(in_ch.char_code == CH_NEWLINE);
		pat_bit   = (in_ch.char_code != CH_ZERO);
		acc_ins   = word_accumulator_q | (WORD_W'(pat_bit) << bit_position_q);
		word_full = (bit_position_q == LAST_BIT);
		col_inc   = column_count_q + DIM_W'(1);
		row_end   = (col_inc >= w_eff);
		ok        = !overflow_seen_q && (row_count_q == h_eff) && (column_count_q == '0);

		if (in_ch.end_of_text) begin
			// Flush a partial word, then report the status and clear.
			res_b.result_kind = KIND_STATUS;
			res_b.size_ok     = ok;
			res_b.is_solid    = ok & all_ones_seen_q;
			res_b.last_of_run = 1'b1;
			if (bit_position_q != '0) begin
				res_a.result_kind = KIND_WORD;
				res_a.bitmap_word = word_accumulator_q;
				push_n            = 2'd2;
			end else begin
				res_a  = res_b;
				push_n = 2'd1;
			end
			column_count_d     = '0;
			row_count_d        = '0;
			bit_position_d     = '0;
			word_accumulator_d = '0;
			all_ones_seen_d    = 1'b1;
			overflow_seen_d    = 1'b0;
		end else if (!is_space) begin
			if (overflow_seen_q || (row_count_q >= h_eff)) begin
				overflow_seen_d = 1'b1;
			end else begin
				if (!pat_bit) begin
					all_ones_seen_d = 1'b0;
				end
				word_accumulator_d = acc_ins;
				bit_position_d     = bit_position_q + POS_W'(1);
				column_count_d     = col_inc;
				if (word_full || row_end) begin
					res_a.result_kind  = KIND_WORD;
					res_a.bitmap_word  = acc_ins;
					push_n             = 2'd1;
					word_accumulator_d = '0;
					bit_position_d     = '0;
				end
				if (row_end) begin
					column_count_d = '0;
					row_count_d    = row_count_q + DIM_W'(1);
				end
			end
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q     <= '0;
			row_count_q        <= '0;
			bit_position_q     <= '0;
			word_accumulator_q <= '0;
			all_ones_seen_q    <= 1'b1;
			overflow_seen_q    <= 1'b0;
		end else if (accept) begin
			column_count_q     <= column_count_d;
			row_count_q        <= row_count_d;
			bit_position_q     <= bit_position_d;
			word_accumulator_q <= word_accumulator_d;
			all_ones_seen_q    <= all_ones_seen_d;
			overflow_seen_q    <= overflow_seen_d;
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (accept && (push_n != 2'd0)) begin
			queue_q[wr_ptr_q] <= res_a;
		end
		if (accept && (push_n == 2'd2)) begin
			queue_q[wr_ptr_q + QPTR_W'(1)] <= res_b;
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (accept ? QCNT_W'(push_n) : '0) - QCNT_W'(pop);
		end
	end

	// Output side of the queue.
	assign out_ch.valid       = (count_q != '0);
	assign out_ch.result_kind = queue_q[rd_ptr_q].result_kind;
	assign out_ch.bitmap_word = queue_q[rd_ptr_q].bitmap_word;
	assign out_ch.size_ok     = queue_q[rd_ptr_q].size_ok;
	assign out_ch.is_solid    = queue_q[rd_ptr_q].is_solid;
	assign out_ch.last_of_run = queue_q[rd_ptr_q].last_of_run;

endmodule
`default_nettype wire
